@@ rtl/hdsep_pkg.sv @@
// Shared types and constants for the Huffman decoder with separator split.
// Used by the modules under rtl/ except hdsep_ram; has no dependencies of its own.
package hdsep_pkg;

  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned NODE_DEPTH   = 512;
  localparam int unsigned SEP_LEN      = 8;

  localparam int unsigned NODE_W = $clog2(NODE_DEPTH);
  localparam int unsigned USED_W = $clog2(NODE_DEPTH + 1);
  localparam int unsigned MC_W   = (SEP_LEN > 1) ? $clog2(SEP_LEN) : 1;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned CIDX_W = $clog2(CODE_W);
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned FNUM_W = 16;

  // separator text, first character in the top byte
  localparam logic [63:0] SEP_STR = {"FILE", "_", "SEP"};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_NEWFILE = 2'd1,
    KIND_BADCODE = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        out_byte;
    logic [FNUM_W-1:0] file_number;
    logic              last;
  } out_item_t;

  // one result before its last flag is known
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        out_byte;
    logic [FNUM_W-1:0] file_number;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } push_t;

  // walker to separator matcher
  typedef struct packed {
    logic       take;
    logic       flush;
    logic [7:0] sym;
  } mreq_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [7:0]        sym;
  } node_t;

  function automatic logic [7:0] sep_char(input logic [2:0] idx);
    sep_char = SEP_STR[8*(7-int'(idx)) +: 8];
  endfunction

endpackage

@@ rtl/hdsep_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module hdsep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hdsep_match.sv @@
// Separator matcher: holds partial separator matches, releases them on a
// mismatch, counts files. Depends on hdsep_pkg.
module hdsep_match import hdsep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mreq_t             mreq_i,
  input  logic              rdy_i,
  output push_t             push_o,
  output logic              busy_o,
  output logic [FNUM_W-1:0] file_cnt_o
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_HELD = 4'b0010,
    M_SYM  = 4'b0100,
    M_NEWF = 4'b1000
  } m_state_e;

  m_state_e          st_q, st_d;
  logic [MC_W-1:0]   mc_q, mc_d;
  logic [MC_W-1:0]   idx_q, idx_d;
  logic              open_q, open_d;
  logic              flush_q, flush_d;
  logic [FNUM_W-1:0] cnt_q, cnt_d;
  logic [7:0]        sym_q, sym_d;
  logic [FNUM_W-1:0] cnt_inc;
  logic              held_done;

  assign cnt_inc   = (cnt_q != '1) ? cnt_q + FNUM_W'(1) : cnt_q;
  assign held_done = ({1'b0, idx_q} + (MC_W+1)'(1)) == {1'b0, mc_q};

  always_comb begin
    st_d    = st_q;
    mc_d    = mc_q;
    idx_d   = idx_q;
    open_d  = open_q;
    flush_d = flush_q;
    cnt_d   = cnt_q;
    sym_d   = sym_q;
    push_o  = '0;
    case (st_q)
      M_IDLE: begin
        if (mreq_i.take) begin
          sym_d = mreq_i.sym;
          if (mreq_i.sym == sep_char(3'(mc_q))) begin
            if (mc_q == MC_W'(SEP_LEN - 1)) begin
              mc_d   = '0;
              cnt_d  = cnt_inc;
              open_d = 1'b1;
              st_d   = M_NEWF;
            end else begin
              mc_d = mc_q + MC_W'(1);
            end
          end else if (!open_q) begin
            mc_d = '0;
          end else if (mc_q != '0) begin
            idx_d   = '0;
            flush_d = 1'b0;
            st_d    = M_HELD;
          end else begin
            st_d = M_SYM;
          end
        end else if (mreq_i.flush) begin
          if (open_q && mc_q != '0) begin
            idx_d   = '0;
            flush_d = 1'b1;
            st_d    = M_HELD;
          end else begin
            mc_d   = '0;
            open_d = 1'b0;
            cnt_d  = '0;
          end
        end
      end
      M_HELD: begin
        push_o.vld = 1'b1;
        push_o.res = '{kind: KIND_BYTE, out_byte: sep_char(3'(idx_q)), file_number: cnt_q};
        if (rdy_i) begin
          idx_d = idx_q + MC_W'(1);
          if (held_done) begin
            if (flush_q) begin
              // end of stream: back to the reset state, tree untouched
              mc_d   = '0;
              open_d = 1'b0;
              cnt_d  = '0;
              st_d   = M_IDLE;
            end else begin
              st_d = M_SYM;
            end
          end
        end
      end
      M_SYM: begin
        push_o.vld = 1'b1;
        push_o.res = '{kind: KIND_BYTE, out_byte: sym_q, file_number: cnt_q};
        if (rdy_i) begin
          mc_d = '0;
          st_d = M_IDLE;
        end
      end
      M_NEWF: begin
        push_o.vld = 1'b1;
        push_o.res = '{kind: KIND_NEWFILE, out_byte: 8'd0, file_number: cnt_q};
        if (rdy_i) begin
          st_d = M_IDLE;
        end
      end
      default: begin
        st_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= M_IDLE;
      mc_q    <= '0;
      open_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      flush_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      mc_q    <= mc_d;
      open_q  <= open_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign busy_o     = (st_q != M_IDLE);
  assign file_cnt_o = cnt_q;

endmodule

@@ rtl/hdsep_obuf.sv @@
// Result stage: one pending result (its last flag still open) plus the
// output register. Depends on hdsep_pkg.
module hdsep_obuf import hdsep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      fin_i,
  output logic      rdy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      pend_vld_q, pend_vld_d;
  res_t      pend_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q;
  logic      out_free, push_acc, fin_acc, load_out;

  assign out_free = !out_vld_q || !out_stall_i;
  assign rdy_o    = !pend_vld_q || out_free;
  assign push_acc = push_i.vld && rdy_o;
  assign fin_acc  = fin_i && rdy_o;
  // pending result moves out when a newer one arrives or the item ends
  assign load_out = pend_vld_q && (push_acc || fin_acc);

  always_comb begin
    out_vld_d  = load_out || (out_vld_q && out_stall_i);
    pend_vld_d = pend_vld_q;
    if (push_acc) begin
      pend_vld_d = 1'b1;
    end else if (fin_acc) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      pend_q <= push_i.res;
    end
    if (load_out) begin
      out_q <= '{kind: pend_q.kind, out_byte: pend_q.out_byte,
                 file_number: pend_q.file_number, last: fin_acc};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_push_fin_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.vld && fin_i))
    else $error("push and end of item in the same cycle");
  a_fin_only_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_i |-> rdy_o)
    else $error("end of item raised while result stage is blocked");
`endif

endmodule

@@ rtl/hdsep_tree.sv @@
// Code tree walker: input channel, code insertion, bit-serial decode over
// the node store. Depends on hdsep_pkg and hdsep_ram.
module hdsep_tree import hdsep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  input  logic              m_busy_i,
  input  logic [FNUM_W-1:0] file_cnt_i,
  output mreq_t             mreq_o,
  output push_t             push_o,
  input  logic              rdy_i,
  output logic              fin_o
);

  typedef enum logic [6:0] {
    T_IDLE  = 7'b0000001,
    T_ISTEP = 7'b0000010,
    T_ISYM  = 7'b0000100,
    T_DLOAD = 7'b0001000,
    T_DBIT  = 7'b0010000,
    T_FLUSH = 7'b0100000,
    T_FIN   = 7'b1000000
  } t_state_e;

  typedef enum logic [1:0] {
    SRC_ROOT = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_ZERO = 2'd2
  } src_e;

  t_state_e          st_q, st_d;
  src_e              src_q, src_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [NODE_W-1:0] root_l_q, root_l_d, root_r_q, root_r_d;
  logic              walk_root_q, walk_root_d;
  logic [3:0]        bcnt_q, bcnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [NODE_W-1:0] node_q, node_d, walk_q, walk_d;
  logic [7:0]        byte_q, byte_d, sym_q, sym_d;
  logic [CODE_W-1:0] code_q, code_d;

  logic                   ram_we, ram_re;
  logic [NODE_W-1:0]      ram_waddr, ram_raddr;
  node_t                  ram_wdata, rd_node, e_ins, e_dec, upd, root_node;
  logic [$bits(node_t)-1:0] ram_rdata;
  logic [LEN_W-1:0]       code_pos, len_sat;
  logic                   code_bit, full, leaf;
  logic [NODE_W-1:0]      slot, nxt, new_idx;

  hdsep_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_DEPTH)) u_nodes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_node   = node_t'(ram_rdata);
  assign root_node = '{left: root_l_q, right: root_r_q, sym: 8'd0};

  always_comb begin
    case (src_q)
      SRC_ROOT: e_ins = root_node;
      SRC_RAM:  e_ins = rd_node;
      default:  e_ins = '0;
    endcase
  end

  assign e_dec = walk_root_q ? root_node : rd_node;

  assign len_sat  = ({1'b0, in_item_i.code_length} > (LEN_W+1)'(MAX_CODE_LEN)) ?
                    LEN_W'(MAX_CODE_LEN) : in_item_i.code_length;
  assign code_pos = rem_q - LEN_W'(1);
  assign code_bit = (code_pos < LEN_W'(CODE_W)) && code_q[code_pos[CIDX_W-1:0]];
  assign slot     = code_bit ? e_ins.right : e_ins.left;
  assign nxt      = byte_q[7] ? e_dec.right : e_dec.left;
  assign full     = (used_q == USED_W'(NODE_DEPTH));
  assign new_idx  = used_q[NODE_W-1:0];
  assign leaf     = !walk_root_q && rd_node.left == '0 && rd_node.right == '0;

  always_comb begin
    upd = e_ins;
    if (code_bit) begin
      upd.right = new_idx;
    end else begin
      upd.left = new_idx;
    end
  end

  always_comb begin
    st_d        = st_q;
    src_d       = src_q;
    used_d      = used_q;
    root_l_d    = root_l_q;
    root_r_d    = root_r_q;
    walk_root_d = walk_root_q;
    bcnt_d      = bcnt_q;
    rem_d       = rem_q;
    node_d      = node_q;
    walk_d      = walk_q;
    byte_d      = byte_q;
    sym_d       = sym_q;
    code_d      = code_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = e_ins;
    ram_re      = 1'b0;
    ram_raddr   = walk_q;
    push_o      = '0;
    mreq_o      = '0;
    fin_o       = 1'b0;
    case (st_q)
      T_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.cmd)
            CMD_INSERT: begin
              sym_d  = in_item_i.symbol;
              code_d = in_item_i.code_bits;
              rem_d  = len_sat;
              node_d = '0;
              src_d  = SRC_ROOT;
              st_d   = (len_sat == '0) ? T_FIN : T_ISTEP;
            end
            CMD_DECODE: begin
              byte_d = in_item_i.data_byte;
              bcnt_d = 4'd8;
              st_d   = walk_root_q ? T_DBIT : T_DLOAD;
            end
            CMD_FLUSH: begin
              st_d = T_FLUSH;
            end
            default: begin
              st_d = T_FIN;
            end
          endcase
        end
      end
      T_ISTEP: begin
        if (slot != '0) begin
          // existing child: fetch it, descend
          ram_re    = 1'b1;
          ram_raddr = slot;
          node_d    = slot;
          src_d     = SRC_RAM;
          rem_d     = rem_q - LEN_W'(1);
          st_d      = (rem_q == LEN_W'(1)) ? T_ISYM : T_ISTEP;
        end else if (full) begin
          push_o.vld = 1'b1;
          push_o.res = '{kind: KIND_FULL, out_byte: 8'd0, file_number: file_cnt_i};
          if (rdy_i) begin
            // a node allocated on the previous step still needs its clear
            ram_we = (src_q == SRC_ZERO);
            st_d   = T_FIN;
          end
        end else begin
          if (src_q == SRC_ROOT) begin
            root_l_d = upd.left;
            root_r_d = upd.right;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = upd;
          end
          used_d = used_q + USED_W'(1);
          node_d = new_idx;
          src_d  = SRC_ZERO;
          rem_d  = rem_q - LEN_W'(1);
          st_d   = (rem_q == LEN_W'(1)) ? T_ISYM : T_ISTEP;
        end
      end
      T_ISYM: begin
        ram_we        = 1'b1;
        ram_wdata     = e_ins;
        ram_wdata.sym = sym_q;
        st_d          = T_FIN;
      end
      T_DLOAD: begin
        // node store may have changed since the walk paused
        ram_re = 1'b1;
        st_d   = T_DBIT;
      end
      T_DBIT: begin
        if (!m_busy_i) begin
          if (leaf) begin
            mreq_o.take = 1'b1;
            mreq_o.sym  = rd_node.sym;
            walk_root_d = 1'b1;
          end else if (bcnt_q == 4'd0) begin
            st_d = T_FIN;
          end else if (nxt == '0) begin
            push_o.vld = 1'b1;
            push_o.res = '{kind: KIND_BADCODE, out_byte: 8'd0, file_number: file_cnt_i};
            if (rdy_i) begin
              walk_root_d = 1'b1;
              byte_d      = {byte_q[6:0], 1'b0};
              bcnt_d      = bcnt_q - 4'd1;
            end
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = nxt;
            walk_d      = nxt;
            walk_root_d = 1'b0;
            byte_d      = {byte_q[6:0], 1'b0};
            bcnt_d      = bcnt_q - 4'd1;
          end
        end
      end
      T_FLUSH: begin
        if (!m_busy_i) begin
          mreq_o.flush = 1'b1;
          walk_root_d  = 1'b1;
          st_d         = T_FIN;
        end
      end
      T_FIN: begin
        if (!m_busy_i && rdy_i) begin
          fin_o = 1'b1;
          st_d  = T_IDLE;
        end
      end
      default: begin
        st_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      src_q       <= SRC_ROOT;
      used_q      <= USED_W'(1);
      root_l_q    <= '0;
      root_r_q    <= '0;
      walk_root_q <= 1'b1;
      bcnt_q      <= '0;
      rem_q       <= '0;
    end else begin
      st_q        <= st_d;
      src_q       <= src_d;
      used_q      <= used_d;
      root_l_q    <= root_l_d;
      root_r_q    <= root_r_d;
      walk_root_q <= walk_root_d;
      bcnt_q      <= bcnt_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    walk_q <= walk_d;
    byte_q <= byte_d;
    sym_q  <= sym_d;
    code_q <= code_d;
  end

  assign in_stall_o = (st_q != T_IDLE);

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= USED_W'(NODE_DEPTH)))
    else $error("node allocation count out of range");
  a_no_root_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (ram_raddr != '0))
    else $error("node store read of the root entry");
  a_no_root_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0))
    else $error("node store write to the root entry");
`endif

endmodule

@@ rtl/huffman_decoder_with_separator_split_top.sv @@
// Top level of the Huffman decoder with separator split.
// Depends on hdsep_pkg, hdsep_tree, hdsep_match, hdsep_obuf.
//
//  - Input channel (in_valid_i / in_stall_o / in_item_i): one command per
//    transfer. cmd 0 inserts a code into the node store, cmd 1 decodes one
//    compressed byte MSB first, cmd 2 ends the stream, cmd 3 is ignored.
//  - Output channel (out_valid_o / out_stall_i / out_item_o): zero or more
//    results per command; the final one of a command carries last = 1.
//  - After a transfer in_stall_o stays high until the command closes: an insert
//    takes a node store step per bit, a symbol write and the close; a zero
//    length insert or cmd 3 just closes, cmd 2 flushes then closes; a decode
//    takes a node store read per bit, an end check and the close, plus a step for each
//    symbol found, for resuming a partially walked code and for each matcher result.
//  - A command is taken only after the previous one has finished; a result
//    is held back one slot until it is known whether more follow.
//  - Reset clears the root node, the allocation count, the walk and the
//    matcher; other node entries are written when allocated, so there is no
//    clearing pass and the block takes commands right after reset.
//  - When the receiver stalls, results wait in the output register and one
//    pending slot; the walker then stops until room frees up.
module huffman_decoder_with_separator_split_top import hdsep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  mreq_t             mreq;
  push_t             t_push, m_push, push;
  logic              m_busy;
  logic [FNUM_W-1:0] file_cnt;
  logic              rdy, fin;

  hdsep_tree u_tree (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .m_busy_i  (m_busy),
    .file_cnt_i(file_cnt),
    .mreq_o    (mreq),
    .push_o    (t_push),
    .rdy_i     (rdy),
    .fin_o     (fin)
  );

  hdsep_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mreq_i    (mreq),
    .rdy_i     (rdy),
    .push_o    (m_push),
    .busy_o    (m_busy),
    .file_cnt_o(file_cnt)
  );

  // matcher only pushes while busy, walker only while matcher is idle
  assign push = m_busy ? m_push : t_push;

  hdsep_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .fin_i      (fin),
    .rdy_o      (rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ dv/huffman_decoder_with_separator_split_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for huffman_decoder_with_separator_split_top: a cycle-free model of the code tree
// and separator matcher predicts every result, a monitor checks them in order.
// Depends on hdsep_pkg and the top level RTL only.
module huffman_decoder_with_separator_split_top_tb;
  import hdsep_pkg::*;

  // cmd code the block ignores
  localparam logic [1:0]  CMD_NOP      = 2'd3;
  localparam int unsigned RUN_LIMIT    = 300000;
  localparam int unsigned HOLD_AT      = 30;   // transfers in before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [63:0] SEP_WORD     = {"FILE", "_", "SEP"};
  // symbol of each 3-bit code in the well-formed streams, code 0 in the top byte
  localparam logic [63:0] ALPHA_WORD   = "FILE_SPA";

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  huffman_decoder_with_separator_split_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tree / matcher model state
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] tree_left  [NODE_DEPTH];
  logic [NODE_W-1:0] tree_right [NODE_DEPTH];
  logic [7:0]        tree_sym   [NODE_DEPTH];
  int unsigned       tree_used;
  int unsigned       walk_at;
  int unsigned       sep_held;   // separator characters matched so far
  logic              file_is_open;
  logic [FNUM_W-1:0] file_num;

  res_t      cmd_results[$];   // results of the command being modeled
  out_item_t result_q[$];      // results still owed by the block
  in_item_t  cmd_q[$];         // commands not yet offered

  int unsigned cyc = 0;
  int unsigned n_items;
  int unsigned n_sent = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0, n_newfile = 0, n_badcode = 0, n_full = 0;
  int unsigned hold_left;
  logic        hold_armed;

  // bit packer for well-formed streams
  logic [7:0]  pack_acc;
  int unsigned pack_n;

  function automatic logic [7:0] sep_at(int unsigned idx);
    logic [63:0] w;
    w = SEP_WORD << (8 * idx);
    return w[63:56];
  endfunction

  function automatic logic [7:0] alpha_at(int unsigned idx);
    logic [63:0] w;
    w = ALPHA_WORD << (8 * idx);
    return w[63:56];
  endfunction

  function automatic int unsigned code_of(logic [7:0] c);
    for (int unsigned i = 0; i < 8; i++)
      if (alpha_at(i) == c) return i;
    return 7;
  endfunction

  function automatic void note(kind_e k, logic [7:0] b);
    res_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.file_number = file_num;
    cmd_results.push_back(r);
  endfunction

  function automatic void emit_char(logic [7:0] c);
    if (file_is_open) note(KIND_BYTE, c);
  endfunction

  function automatic void release_held();
    for (int unsigned i = 0; i < sep_held; i++) emit_char(sep_at(i));
  endfunction

  // no fallback: a mismatch releases the held prefix and the symbol, match restarts at zero
  function automatic void take_symbol(logic [7:0] sym);
    if (sep_held < SEP_LEN && sym == sep_at(sep_held)) begin
      sep_held++;
      if (sep_held >= SEP_LEN) begin
        sep_held = 0;
        if (file_num != '1) file_num++;
        file_is_open = 1'b1;
        note(KIND_NEWFILE, 8'h00);
      end
    end else begin
      release_held();
      emit_char(sym);
      sep_held = 0;
    end
  endfunction

  function automatic void tree_insert(logic [7:0] sym, logic [31:0] bits, logic [5:0] len_in);
    int unsigned len;
    int unsigned node;
    int unsigned nxt;
    logic        b;
    len  = (len_in > MAX_CODE_LEN) ? MAX_CODE_LEN : len_in;
    node = 0;
    for (int i = int'(len) - 1; i >= 0; i--) begin
      b   = bits[i];
      nxt = b ? tree_right[node] : tree_left[node];
      if (nxt == 0) begin
        // out of nodes: rest of the code dropped, nodes taken so far stay
        if (tree_used >= NODE_DEPTH) begin
          note(KIND_FULL, 8'h00);
          return;
        end
        nxt = tree_used;
        tree_used++;
        tree_left[nxt]  = '0;
        tree_right[nxt] = '0;
        tree_sym[nxt]   = '0;
        if (b) tree_right[node] = NODE_W'(nxt);
        else   tree_left[node]  = NODE_W'(nxt);
      end
      node = nxt;
    end
    if (len != 0) tree_sym[node] = sym;
  endfunction

  function automatic void tree_decode(logic [7:0] db);
    int unsigned nxt;
    for (int i = 7; i >= 0; i--) begin
      nxt = db[i] ? tree_right[walk_at] : tree_left[walk_at];
      if (nxt == 0) begin
        note(KIND_BADCODE, 8'h00);
        walk_at = 0;
      end else if (tree_left[nxt] == 0 && tree_right[nxt] == 0) begin
        take_symbol(tree_sym[nxt]);
        walk_at = 0;
      end else begin
        walk_at = nxt;
      end
    end
  endfunction

  // model one accepted command and queue what it must produce
  function automatic void tree_step(in_item_t it);
    out_item_t o;
    cmd_results.delete();
    case (it.cmd)
      CMD_INSERT: tree_insert(it.symbol, it.code_bits, it.code_length);
      CMD_DECODE: tree_decode(it.data_byte);
      CMD_FLUSH: begin
        release_held();
        walk_at      = 0;
        sep_held     = 0;
        file_is_open = 1'b0;
        file_num     = '0;
      end
      default: ;
    endcase
    foreach (cmd_results[i]) begin
      o.kind        = cmd_results[i].kind;
      o.out_byte    = cmd_results[i].out_byte;
      o.file_number = cmd_results[i].file_number;
      o.last        = (i == cmd_results.size() - 1);
      result_q.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(logic [1:0] c, logic [7:0] sym, logic [31:0] bits,
                                   logic [5:0] len, logic [7:0] db);
    in_item_t it;
    it.cmd         = c;
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    it.data_byte   = db;
    cmd_q.push_back(it);
  endfunction

  // unused fields carry random noise
  function automatic void push_insert(logic [7:0] sym, logic [31:0] bits, logic [5:0] len);
    push_cmd(CMD_INSERT, sym, bits, len, 8'($urandom));
  endfunction

  function automatic void push_decode(logic [7:0] db);
    push_cmd(CMD_DECODE, 8'($urandom), $urandom, 6'($urandom), db);
  endfunction

  function automatic void push_other(logic [1:0] c);
    push_cmd(c, 8'($urandom), $urandom, 6'($urandom), 8'($urandom));
  endfunction

  function automatic void push_char(int unsigned code);
    logic [2:0] c;
    c = 3'(code);
    for (int k = 2; k >= 0; k--) begin
      pack_acc = {pack_acc[6:0], c[k]};
      pack_n++;
      if (pack_n == 8) begin
        push_decode(pack_acc);
        pack_n = 0;
      end
    end
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(code_of(s[i]));
  endfunction

  // the whole separator as coded characters
  function automatic void push_sep();
    for (int unsigned k = 0; k < SEP_LEN; k++) push_char(code_of(sep_at(k)));
  endfunction

  // finish the current byte with random bits; may leave a partly walked code
  function automatic void pad_stream();
    while (pack_n != 0) begin
      pack_acc = {pack_acc[6:0], 1'($urandom)};
      pack_n   = (pack_n + 1) % 8;
      if (pack_n == 0) push_decode(pack_acc);
    end
  endfunction

  // per-transfer wait, with recurring calm stretches of back-to-back traffic
  function automatic int unsigned draw_wait();
    if (cyc % 2048 < 400) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued commands, models each one on its transfer
  // ---------------------------------------------------------------------------
  int unsigned drv_wait;

  always @(posedge clk_i) begin
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_wait = $urandom_range(0, 13);
      // model reset: root only
      tree_left[0]  = '0;
      tree_right[0] = '0;
      tree_sym[0]   = '0;
      tree_used     = 1;
      walk_at       = 0;
      sep_held      = 0;
      file_is_open  = 1'b0;
      file_num      = '0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        tree_step(in_item_i);
        n_sent <= n_sent + 1;
        offer    = 1'b0;
        drv_wait = draw_wait();
      end
      if (!offer) begin
        if (drv_wait != 0) begin
          drv_wait--;
        end else if (cmd_q.size() != 0) begin
          in_item_i <= cmd_q.pop_front();
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once HOLD_AT transfers are in, the receiver stops for a
  // long stretch while the driver keeps offering, so the block backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && n_sent == HOLD_AT) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is compared with the oldest expectation
  // ---------------------------------------------------------------------------
  int unsigned mon_wait;

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        case (out_item_o.kind)
          KIND_NEWFILE: n_newfile++;
          KIND_BADCODE: n_badcode++;
          KIND_FULL:    n_full++;
          default: ;
        endcase
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_item_o, 0);
        end else begin
          want = result_q.pop_front();
          if (out_item_o.kind != want.kind)
            report_mismatch("kind", out_item_o.kind, want.kind);
          if (out_item_o.out_byte != want.out_byte)
            report_mismatch("out_byte", out_item_o.out_byte, want.out_byte);
          if (out_item_o.file_number != want.file_number)
            report_mismatch("file_number", out_item_o.file_number, want.file_number);
          if (out_item_o.last != want.last)
            report_mismatch("last", out_item_o.last, want.last);
        end
        mon_wait = draw_wait();
      end else if (mon_wait != 0) begin
        mon_wait--;
      end
      out_stall_i <= (mon_wait != 0) || (hold_left != 0);
    end
  end

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == RUN_LIMIT) begin
      $display("[%0t] timeout: %0d of %0d commands sent, %0d results outstanding",
               $time, n_sent, n_items, result_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned n;
    pack_acc  = '0;
    pack_n    = 0;

    // Directed: empty tree gives a bad code on every bit
    push_decode(8'hFF);
    push_decode(8'h00);
    // zero length inserts nothing; unknown command does nothing
    push_insert(8'hFF, 32'hFFFF_FFFF, 6'd0);
    push_other(CMD_NOP);
    // complete 3-bit code: every decode lands on a leaf
    for (int unsigned i = 0; i < 8; i++) push_insert(alpha_at(i), 32'(i), 6'd3);
    // separator with no file open, plain text, a prefix broken by a fresh 'F'
    // (no fallback), a prefix broken mid-way, a second file, then a held prefix
    // released by end of stream
    push_text("P");
    push_sep();
    push_text("LIFE");
    push_text("FILEF");
    push_text("FIL_");
    push_sep();
    push_text("FILE_SE");
    pad_stream();
    push_other(CMD_FLUSH);
    push_other(CMD_FLUSH);

    // Random well-formed streams over the 3-bit code
    while (cmd_q.size() < 85) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        push_sep();
      end else if (r < 7) begin
        n = $urandom_range(1, 7);
        for (int unsigned k = 0; k < n; k++) push_char(code_of(sep_at(k)));
        push_char($urandom_range(0, 7));
      end else if (r < 9) begin
        repeat ($urandom_range(1, 5)) push_char($urandom_range(0, 7));
      end else begin
        pad_stream();
        if ($urandom_range(0, 1) != 0) push_other(CMD_FLUSH);
        else push_other(CMD_NOP);
      end
    end
    pad_stream();

    // Long random codes until the node store runs out; overlong lengths first
    for (int unsigned j = 0; j < 40; j++) begin
      if (j % 4 == 3) push_decode(8'($urandom));
      else if (j < 3) push_insert(8'($urandom), $urandom, 6'd63);
      else if ($urandom_range(0, 3) == 0) push_insert(8'($urandom), $urandom, 6'($urandom));
      else push_insert(8'($urandom), $urandom, 6'd32);
    end

    // Noise: any command, any field values
    while (cmd_q.size() < 135) push_other(2'($urandom));
    n_items = cmd_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_sent == n_items && result_q.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d commands (inserts to a full node store, decodes, stream ends)",
             n_items);
    $display("and %0d results: %0d new files, %0d bad codes, %0d table full; %0d mismatches",
             n_checked, n_newfile, n_badcode, n_full, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hdsep_pkg.sv
rtl/hdsep_ram.sv
rtl/hdsep_match.sv
rtl/hdsep_obuf.sv
rtl/hdsep_tree.sv
rtl/huffman_decoder_with_separator_split_top.sv
dv/huffman_decoder_with_separator_split_top_tb.sv
